### rtl/m4inv_pkg.sv
// Package for the 4x4 matrix inverse core: defaults, controller states,
// and the command and status structs between controller and datapath.
// No dependencies.
package m4inv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  // stored cofactors are signed 64 bits
  localparam int COF_W          = 64;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_COF,
    ST_CROUND,
    ST_DET,
    ST_DET_DONE,
    ST_DIV_LOAD,
    ST_DIV_OVF,
    ST_DIV_STEP,
    ST_EMIT
  } state_t;

  // multiplier operand A source
  typedef enum logic [2:0] {
    MS_NONE,
    MS_MAT,
    MS_DHI,
    MS_DLO,
    MS_CHI,
    MS_CLO
  } mul_src_t;

  typedef enum logic [1:0] {
    D_NONE,
    D_SET,
    D_SUB
  } diff_op_t;

  typedef enum logic [1:0] {
    A_NONE,
    A_CLEAR,
    A_HI,
    A_LO
  } acc_op_t;

  typedef struct packed {
    logic       mat_we;
    logic [3:0] mat_addr;
    logic       ld_x;
    mul_src_t   mul_src;
    diff_op_t   d_op;
    acc_op_t    acc_op;
    logic       acc_neg;
    logic       cof_we;
    logic [3:0] cof_addr;
    logic       det_latch;
    logic       div_load;
    logic       div_ovf;
    logic       div_step;
    logic       emit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic singular;
  } stat_t;

endpackage

### rtl/m4inv_ctrl.sv
// Controller for the 4x4 matrix inverse core: load counter, cofactor
// microsequence, determinant pass and per-entry divide sequencing.
// Depends on m4inv_pkg.
module m4inv_ctrl #(
  parameter int DATA_WIDTH = m4inv_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  m4inv_pkg::stat_t  stat,
  output m4inv_pkg::cmd_t   cmd
);

  localparam int BW = (DATA_WIDTH > 3) ? $clog2(DATA_WIDTH - 1) : 1;

  m4inv_pkg::state_t state, state_next;
  logic [3:0]    lc;     // entries loaded
  logic [3:0]    kc;     // cofactor / entry index
  logic [1:0]    tc;     // minor term
  logic [2:0]    sc;     // step within term
  logic [BW-1:0] bitc;   // quotient bit

  // map n over 0..2 onto 0..3, skipping index x
  function automatic logic [1:0] skip(input logic [1:0] n, input logic [1:0] x);
    skip = (n < x) ? n : n + 2'd1;
  endfunction

  logic [1:0] ci, cj, c1, c2;
  always_comb begin
    ci = kc[3:2];
    cj = kc[1:0];
    c1 = (tc == 2'd0) ? 2'd1 : 2'd0;
    c2 = (tc == 2'd2) ? 2'd1 : 2'd2;
  end

  // matrix address of minor element (n, m): rows skip j, columns skip i
  function automatic logic [3:0] maddr(input logic [1:0] n, input logic [1:0] m,
                                       input logic [1:0] i, input logic [1:0] j);
    maddr = {skip(n, j), skip(m, i)};
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      m4inv_pkg::ST_LOAD:     if (start && lc == 4'd15) state_next = m4inv_pkg::ST_COF;
      m4inv_pkg::ST_COF:      if (sc == 3'd7 && tc == 2'd2) state_next = m4inv_pkg::ST_CROUND;
      m4inv_pkg::ST_CROUND:   state_next = (kc == 4'd15) ? m4inv_pkg::ST_DET : m4inv_pkg::ST_COF;
      m4inv_pkg::ST_DET:      if (sc == 3'd3 && kc == 4'd3) state_next = m4inv_pkg::ST_DET_DONE;
      m4inv_pkg::ST_DET_DONE: state_next = m4inv_pkg::ST_DIV_LOAD;
      m4inv_pkg::ST_DIV_LOAD: state_next = stat.singular ? m4inv_pkg::ST_EMIT
                                                         : m4inv_pkg::ST_DIV_OVF;
      m4inv_pkg::ST_DIV_OVF:  state_next = m4inv_pkg::ST_DIV_STEP;
      m4inv_pkg::ST_DIV_STEP: if (bitc == '0) state_next = m4inv_pkg::ST_EMIT;
      m4inv_pkg::ST_EMIT:     state_next = (kc == 4'd15) ? m4inv_pkg::ST_LOAD
                                                         : m4inv_pkg::ST_DIV_LOAD;
      default:                state_next = m4inv_pkg::ST_LOAD;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4inv_pkg::ST_LOAD;
      lc    <= '0;
      kc    <= '0;
      tc    <= '0;
      sc    <= '0;
      bitc  <= '0;
    end else begin
      state <= state_next;
      case (state)
        m4inv_pkg::ST_LOAD: begin
          if (start) lc <= lc + 4'd1;
          kc <= '0;
          tc <= '0;
          sc <= '0;
        end
        m4inv_pkg::ST_COF: begin
          sc <= sc + 3'd1;
          if (sc == 3'd7 && tc != 2'd2) tc <= tc + 2'd1;
        end
        m4inv_pkg::ST_CROUND: begin
          kc <= kc + 4'd1;
          tc <= '0;
          sc <= '0;
        end
        m4inv_pkg::ST_DET: begin
          if (sc == 3'd3) begin
            sc <= '0;
            kc <= kc + 4'd1;
          end else begin
            sc <= sc + 3'd1;
          end
        end
        m4inv_pkg::ST_DET_DONE: kc <= '0;
        m4inv_pkg::ST_DIV_OVF:  bitc <= BW'(DATA_WIDTH - 2);
        m4inv_pkg::ST_DIV_STEP: bitc <= bitc - 1'b1;
        m4inv_pkg::ST_EMIT:     kc <= kc + 4'd1;
        default: ;
      endcase
    end
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.mat_addr = lc;
    cmd.cof_addr = kc;
    busy         = (state != m4inv_pkg::ST_LOAD);
    case (state)
      m4inv_pkg::ST_LOAD: begin
        cmd.mat_we = start;
      end
      m4inv_pkg::ST_COF: begin
        cmd.acc_neg = (tc == 2'd1) ^ kc[2] ^ kc[0];
        case (sc)
          3'd0: begin
            cmd.ld_x     = 1'b1;
            cmd.mat_addr = maddr(2'd1, c1, ci, cj);
            if (tc == 2'd0) cmd.acc_op = m4inv_pkg::A_CLEAR;
          end
          3'd1: begin
            cmd.mul_src  = m4inv_pkg::MS_MAT;
            cmd.mat_addr = maddr(2'd2, c2, ci, cj);
          end
          3'd2: begin
            cmd.d_op     = m4inv_pkg::D_SET;
            cmd.ld_x     = 1'b1;
            cmd.mat_addr = maddr(2'd1, c2, ci, cj);
          end
          3'd3: begin
            cmd.mul_src  = m4inv_pkg::MS_MAT;
            cmd.mat_addr = maddr(2'd2, c1, ci, cj);
          end
          3'd4: begin
            cmd.d_op     = m4inv_pkg::D_SUB;
            cmd.ld_x     = 1'b1;
            cmd.mat_addr = maddr(2'd0, tc, ci, cj);
          end
          3'd5: cmd.mul_src = m4inv_pkg::MS_DHI;
          3'd6: begin
            cmd.acc_op  = m4inv_pkg::A_HI;
            cmd.mul_src = m4inv_pkg::MS_DLO;
          end
          3'd7: cmd.acc_op = m4inv_pkg::A_LO;
          default: ;
        endcase
      end
      m4inv_pkg::ST_CROUND: cmd.cof_we = 1'b1;
      m4inv_pkg::ST_DET: begin
        case (sc)
          3'd0: begin
            cmd.ld_x     = 1'b1;
            cmd.mat_addr = {kc[1:0], 2'd0};
            if (kc == 4'd0) cmd.acc_op = m4inv_pkg::A_CLEAR;
          end
          3'd1: cmd.mul_src = m4inv_pkg::MS_CHI;
          3'd2: begin
            cmd.acc_op  = m4inv_pkg::A_HI;
            cmd.mul_src = m4inv_pkg::MS_CLO;
          end
          3'd3: cmd.acc_op = m4inv_pkg::A_LO;
          default: ;
        endcase
      end
      m4inv_pkg::ST_DET_DONE: cmd.det_latch = 1'b1;
      m4inv_pkg::ST_DIV_LOAD: cmd.div_load  = 1'b1;
      m4inv_pkg::ST_DIV_OVF:  cmd.div_ovf   = 1'b1;
      m4inv_pkg::ST_DIV_STEP: cmd.div_step  = 1'b1;
      m4inv_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.last = (kc == 4'd15);
      end
      default: ;
    endcase
  end

endmodule

### rtl/m4inv_datapath.sv
// Datapath for the 4x4 matrix inverse core: matrix and cofactor stores,
// shared multiplier, accumulator, restoring divider and result register.
// Depends on m4inv_pkg.
module m4inv_datapath #(
  parameter int DATA_WIDTH = m4inv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  m4inv_pkg::cmd_t              cmd,
  output m4inv_pkg::stat_t             stat,
  input  logic signed [DATA_WIDTH-1:0] entry_value,
  output logic                         valid,
  output logic signed [DATA_WIDTH-1:0] inverse_value,
  output logic [3:0]                   entry_index,
  output logic                         singular,
  output logic                         last_entry
);

  localparam int DW    = DATA_WIDTH;
  localparam int CW    = m4inv_pkg::COF_W;
  localparam int MA    = (DW + 1 > CW - DW) ? DW + 1 : CW - DW;
  localparam int PR_W  = MA + DW;
  localparam int DR_W  = 2 * DW + 1;
  localparam int ACC_A = 3 * DW + 4;
  localparam int ACC_B = CW + DW + 3;
  localparam int ACC_W = (ACC_A > ACC_B) ? ACC_A : ACC_B;
  localparam int REM_A = CW + 2 * FRAC_BITS + 2;
  localparam int REM_B = ACC_W + DW;
  localparam int REM_W = ((REM_A > REM_B) ? REM_A : REM_B) + 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (2 * FRAC_BITS - 1);

  logic signed [DW-1:0]    mat [16];
  logic signed [CW-1:0]    cof [16];
  logic signed [DW-1:0]    xr;
  logic signed [PR_W-1:0]  pr;
  logic signed [DR_W-1:0]  dr;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]        dm;
  logic                    dneg;
  logic                    sing;
  logic [REM_W-1:0]        rem;
  logic [REM_W-1:0]        dsr;
  logic [DW-2:0]           q;
  logic                    ovf;
  logic                    nneg;

  logic signed [DW-1:0]    mat_rd;
  logic signed [CW-1:0]    cof_rd;
  logic signed [MA-1:0]    mul_a;
  logic signed [ACC_W-1:0] pr_ext;
  logic signed [ACC_W-1:0] acc_term;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [CW-1:0]    cof_sat;
  logic [CW-1:0]           nm;
  logic                    rem_ge;
  logic [DW-1:0]           qe;
  logic signed [DW-1:0]    res;

  assign mat_rd = mat[cmd.mat_addr];
  assign cof_rd = cof[cmd.cof_addr];
  assign stat.singular = sing;

  // multiplier operand select
  always_comb begin
    case (cmd.mul_src)
      m4inv_pkg::MS_MAT: mul_a = MA'(mat_rd);
      m4inv_pkg::MS_DHI: mul_a = MA'(signed'(dr[DR_W-1:DW]));
      m4inv_pkg::MS_DLO: mul_a = MA'(signed'({1'b0, dr[DW-1:0]}));
      m4inv_pkg::MS_CHI: mul_a = MA'(signed'(cof_rd[CW-1:DW]));
      m4inv_pkg::MS_CLO: mul_a = MA'(signed'({1'b0, cof_rd[DW-1:0]}));
      default:           mul_a = '0;
    endcase
  end

  // accumulator term, cofactor rounding and saturation
  always_comb begin
    pr_ext   = ACC_W'(pr);
    acc_term = (cmd.acc_op == m4inv_pkg::A_HI) ? (pr_ext <<< DW) : pr_ext;
    acc_rnd  = (acc + HALF) >>> (2 * FRAC_BITS);
    if (&acc_rnd[ACC_W-1:CW-1] || ~|acc_rnd[ACC_W-1:CW-1]) begin
      cof_sat = acc_rnd[CW-1:0];
    end else begin
      cof_sat = acc_rnd[ACC_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  // divider compare and result select
  always_comb begin
    nm     = cof_rd[CW-1] ? CW'(-cof_rd) : CW'(cof_rd);
    rem_ge = (rem >= dsr);
    qe     = {1'b0, q};
    if (sing) begin
      res = '0;
    end else if (ovf) begin
      res = (nneg ^ dneg) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      res = (nneg ^ dneg) ? -signed'(qe) : signed'(qe);
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (cmd.mat_we) mat[cmd.mat_addr] <= entry_value;
    if (cmd.cof_we) cof[cmd.cof_addr] <= cof_sat;
  end

  // multiply, difference and accumulate
  always_ff @(posedge clk) begin
    if (cmd.ld_x) xr <= mat_rd;
    if (cmd.mul_src != m4inv_pkg::MS_NONE) pr <= mul_a * xr;
    case (cmd.d_op)
      m4inv_pkg::D_SET: dr <= signed'(pr[DR_W-1:0]);
      m4inv_pkg::D_SUB: dr <= dr - signed'(pr[DR_W-1:0]);
      default: ;
    endcase
    case (cmd.acc_op)
      m4inv_pkg::A_CLEAR: acc <= '0;
      m4inv_pkg::A_HI,
      m4inv_pkg::A_LO:    acc <= cmd.acc_neg ? acc - acc_term : acc + acc_term;
      default: ;
    endcase
  end

  // determinant and restoring divide
  always_ff @(posedge clk) begin
    if (rst) begin
      sing <= 1'b0;
    end else if (cmd.det_latch) begin
      sing <= (acc == '0);
    end
    if (cmd.det_latch) begin
      dneg <= acc[ACC_W-1];
      dm   <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    end
    if (cmd.div_load) begin
      rem  <= (REM_W'(nm) << (2 * FRAC_BITS + 1)) + REM_W'(dm);
      dsr  <= REM_W'(dm) << DW;
      nneg <= cof_rd[CW-1];
      q    <= '0;
      ovf  <= 1'b0;
    end
    if (cmd.div_ovf) begin
      ovf <= rem_ge;
      dsr <= dsr >> 1;
    end
    if (cmd.div_step) begin
      if (rem_ge) rem <= rem - dsr;
      q   <= {q[DW-3:0], rem_ge};
      dsr <= dsr >> 1;
    end
  end

  // result register, one strobe per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
    if (cmd.emit) begin
      inverse_value <= res;
      entry_index   <= cmd.cof_addr;
      singular      <= sing;
      last_entry    <= cmd.last;
    end
  end

endmodule

### rtl/matrix4x4_inverse_core.sv
// Top level of the 4x4 matrix inverse core (adjugate over determinant).
// Depends on m4inv_pkg, m4inv_ctrl and m4inv_datapath.
//
// Entries of a signed Q-format 4x4 matrix are taken one per transaction, in
// row-major order, at each clock edge with start high and busy low. On the
// sixteenth entry busy rises and the core forms the sixteen cofactors
// through one shared multiplier, then the determinant. Each inverse entry
// then comes from a restoring divider that resolves one quotient bit per
// cycle; one entry's divide finishes before the next one begins, and a
// singular matrix skips the divide. Results appear on inverse_value,
// entry_index, singular and last_entry for exactly one cycle with valid
// high; the receiver cannot stall them. Busy falls with the sixteenth
// result.
module matrix4x4_inverse_core #(
  parameter int DATA_WIDTH = m4inv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] entry_value,
  output logic                         valid,
  output logic signed [DATA_WIDTH-1:0] inverse_value,
  output logic [3:0]                   entry_index,
  output logic                         singular,
  output logic                         last_entry
);

  m4inv_pkg::cmd_t  cmd;
  m4inv_pkg::stat_t stat;

  m4inv_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  m4inv_datapath #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .entry_value   (entry_value),
    .valid         (valid),
    .inverse_value (inverse_value),
    .entry_index   (entry_index),
    .singular      (singular),
    .last_entry    (last_entry)
  );

endmodule

### rtl/m4inv_checker.sv
// Port-level checker for the 4x4 matrix inverse core, bound to the top level.
// Depends on m4inv_pkg and matrix4x4_inverse_core.
module m4inv_assert #(
  parameter int DATA_WIDTH = m4inv_pkg::DATA_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         valid,
  input logic signed [DATA_WIDTH-1:0] inverse_value,
  input logic [3:0]                   entry_index,
  input logic                         singular,
  input logic                         last_entry
);

  // last mark only on the final entry of a matrix
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last_entry == (entry_index == 4'd15)))
    else $error("last_entry does not match entry_index");

  // singular matrices give zero entries
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    valid && singular |-> inverse_value == '0)
    else $error("singular result not zero");

  // more results follow while the core stays busy
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    valid && !last_entry |-> busy)
    else $error("core idle in the middle of a result sequence");

  // indices advance by one and singular holds within a matrix
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    valid && !last_entry |=> !valid || (entry_index == $past(entry_index) + 4'd1
                                        && singular == $past(singular)))
    else $error("result index or singular flag out of sequence");

  // no result while entries of a new matrix are being taken
  a_no_res_load: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> !valid || last_entry)
    else $error("result during matrix load");

endmodule

bind matrix4x4_inverse_core m4inv_assert #(
  .DATA_WIDTH(DATA_WIDTH)
) u_m4inv_assert (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .valid         (valid),
  .inverse_value (inverse_value),
  .entry_index   (entry_index),
  .singular      (singular),
  .last_entry    (last_entry)
);

### verif/m4inv_checker.sv
// Scoreboard for the 4x4 matrix inverse core: watches the entry and result
// channels, predicts each inverse in wide fixed point and compares.
// Depends on m4inv_pkg.
`timescale 1ns / 100ps

module m4inv_checker #(
  parameter int DATA_WIDTH = m4inv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] entry_value,
  input  logic                         valid,
  input  logic signed [DATA_WIDTH-1:0] inverse_value,
  input  logic [3:0]                   entry_index,
  input  logic                         singular,
  input  logic                         last_entry,
  output int                           errors,
  output int                           pending
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] value;
    logic [3:0]                   index;
    logic                         sing;
    logic                         last;
  } inv_entry_t;

  inv_entry_t inv_q[$];
  wide_t      mat[16];
  int         load_cnt;

  // clamp a wide value to signed 'bits' bits
  function automatic wide_t clamp(wide_t x, int bits);
    wide_t hi;
    hi = 1;
    hi = hi <<< (bits - 1);
    if (x >= hi) return hi - 1;
    if (x < -hi) return -hi;
    return x;
  endfunction

  // signed 3x3 minor of the held matrix: drop row r and column c
  function automatic wide_t minor3(int r, int c);
    int    rs[3];
    int    cs[3];
    int    n;
    wide_t a[3][3];
    wide_t d;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != r) begin rs[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != c) begin cs[n] = k; n++; end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = mat[rs[i]*4 + cs[j]];
    d = a[0][0] * (a[1][1]*a[2][2] - a[1][2]*a[2][1])
      - a[0][1] * (a[1][0]*a[2][2] - a[1][2]*a[2][0])
      + a[0][2] * (a[1][0]*a[2][1] - a[1][1]*a[2][0]);
    return d;
  endfunction

  // adjugate, determinant and rounded division for all sixteen entries
  task automatic predict_inverse();
    wide_t      cof[16];
    wide_t      adj, half, det, num;
    logic [255:0] nm, dm, q;
    logic       dneg, nneg, sing;
    inv_entry_t e;
    half = 1;
    half = half <<< (2*FRAC_BITS - 1);
    for (int k = 0; k < 16; k++) begin
      // adjugate (i,j) is the cofactor of M at (j,i)
      adj = minor3(k & 3, k >> 2);
      if (((k >> 2) + (k & 3)) % 2 == 1) adj = -adj;
      cof[k] = clamp((adj + half) >>> (2*FRAC_BITS), 64);
    end
    det = 0;
    for (int k = 0; k < 4; k++) det = det + mat[k*4] * cof[k];
    sing = (det == 0);
    dneg = det < 0;
    dm = dneg ? -det : det;
    for (int k = 0; k < 16; k++) begin
      e.value = '0;
      if (!sing) begin
        num = cof[k] <<< (2*FRAC_BITS);
        nneg = num < 0;
        nm = nneg ? -num : num;
        q = (2*nm + dm) / (2*dm);
        e.value = DATA_WIDTH'(clamp((nneg != dneg) ? -wide_t'(q) : wide_t'(q),
                                    DATA_WIDTH));
      end
      e.index = k[3:0];
      e.sing = sing;
      e.last = (k == 15);
      inv_q.push_back(e);
    end
  endtask

  // entry side: collect the matrix, predict on the sixteenth entry
  always @(posedge clk) begin
    if (rst) begin
      load_cnt <= 0;
    end else if (start && !busy) begin
      mat[load_cnt] = wide_t'(entry_value);
      if (load_cnt == 15) begin
        load_cnt <= 0;
        predict_inverse();
      end else begin
        load_cnt <= load_cnt + 1;
      end
    end
  end

  // result side: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    inv_entry_t e;
    if (!rst && valid) begin
      if (inv_q.size() == 0) begin
        $error("unexpected result: index %0d value %0d", entry_index, inverse_value);
        errors++;
      end else begin
        e = inv_q.pop_front();
        if (inverse_value !== e.value) begin
          $error("inverse_value: expected %0d, got %0d", e.value, inverse_value);
          errors++;
        end
        if (entry_index !== e.index) begin
          $error("entry_index: expected %0d, got %0d", e.index, entry_index);
          errors++;
        end
        if (singular !== e.sing) begin
          $error("singular: expected %0b, got %0b", e.sing, singular);
          errors++;
        end
        if (last_entry !== e.last) begin
          $error("last_entry: expected %0b, got %0b", e.last, last_entry);
          errors++;
        end
      end
    end
    pending = inv_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    load_cnt = 0;
  end

endmodule

### verif/tb.sv
// Testbench top for matrix4x4_inverse_core: drives matrices of entries and
// gives the verdict. Depends on m4inv_pkg, the core and m4inv_checker.
`timescale 1ns / 100ps

module tb;

  localparam int DW = m4inv_pkg::DATA_WIDTH_DEF;
  localparam int FB = m4inv_pkg::FRAC_BITS_DEF;
  localparam int ONE = 1 << FB;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [DW-1:0] entry_value;
  logic                 valid;
  logic signed [DW-1:0] inverse_value;
  logic [3:0]           entry_index;
  logic                 singular;
  logic                 last_entry;
  int                   errors;
  int                   pending;
  int                   cycles;
  int                   idle_pct;
  logic signed [DW-1:0] mtx[16];

  matrix4x4_inverse_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .entry_value(entry_value),
    .valid(valid), .inverse_value(inverse_value), .entry_index(entry_index),
    .singular(singular), .last_entry(last_entry)
  );

  m4inv_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .entry_value(entry_value),
    .valid(valid), .inverse_value(inverse_value), .entry_index(entry_index),
    .singular(singular), .last_entry(last_entry), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("matrix4x4_inverse_core: mismatch");
        $finish;
      end
    end
  end

  // one entry transaction; start stays high on return
  task automatic send_entry(logic signed [DW-1:0] v);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    entry_value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_matrix();
    for (int k = 0; k < 16; k++) send_entry(mtx[k]);
  endtask

  // random matrix of a randomly chosen flavor
  task automatic fill_random();
    int kind;
    int src;
    kind = $urandom_range(9);
    for (int k = 0; k < 16; k++) begin
      case (kind)
        0, 1, 2, 3: begin
          // heavier diagonal, unit-range off-diagonal entries
          mtx[k] = $signed($urandom_range(0, 2*ONE)) - ONE;
          if (k % 5 == 0)
            mtx[k] = ($urandom_range(1) ? 1 : -1) * ($urandom_range(4, 40) * ONE / 4);
        end
        4, 5: mtx[k] = $urandom;
        6:    mtx[k] = $signed($urandom_range(0, 2*64*ONE)) - 64*ONE;
        7:    mtx[k] = $signed($urandom_range(0, 2000)) - 1000;
        default: mtx[k] = $signed($urandom_range(0, 8*ONE)) - 4*ONE;
      endcase
    end
    // singular: repeat one row
    if (kind == 9 || kind == 3) begin
      src = $urandom_range(3);
      for (int c = 0; c < 4; c++) mtx[((src + 1) % 4)*4 + c] = mtx[src*4 + c];
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    entry_value = '0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extreme diagonal: tiny and full-scale entries, saturating inverse
    mtx = '{default: '0};
    mtx[0] = 1;
    mtx[5] = -1;
    mtx[10] = {1'b0, {(DW-1){1'b1}}};
    mtx[15] = {1'b1, {(DW-1){1'b0}}};
    send_matrix();
    // zero matrix: singular
    mtx = '{default: '0};
    send_matrix();

    // let the core drain fully before the random part
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);

    for (int m = 0; m < 19; m++) begin
      case (m / 5)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 13;
        default: idle_pct = 46;
      endcase
      fill_random();
      send_matrix();
    end
    start <= 1'b0;

    // wait for the last matrix to be fully answered
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("matrix4x4_inverse_core: match");
    end else begin
      $display("matrix4x4_inverse_core: mismatch");
    end
    $finish;
  end

endmodule
